>>> hw/rtl/sorted_store_insert_delete_core_defines.svh
// ----------------------------------------------------------------------------
// sorted_store_insert_delete_core_defines
// Assertion macros for the sorted store.
// ----------------------------------------------------------------------------
`ifndef SORTED_STORE_INSERT_DELETE_CORE_DEFINES_SVH
`define SORTED_STORE_INSERT_DELETE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SSID_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ssid check failed");

// Next-cycle implication, disabled while in reset.
`define SSID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ssid check failed");

`endif

>>> hw/rtl/ssid_pkg.sv
// ----------------------------------------------------------------------------
// ssid_pkg
// Shared types, codes and sizes of the sorted store.
// ----------------------------------------------------------------------------
package ssid_pkg;

	localparam int STORE_DEPTH_DEF = 16;
	localparam int VALUE_W         = 32;
	localparam int REQ_W           = 2;
	localparam int STATUS_W        = 2;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DUMP   = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd3;

	// Cell operations
	typedef logic [1:0] cell_op_t;
	localparam cell_op_t CELL_HOLD = 2'd0;
	localparam cell_op_t CELL_INS  = 2'd1;
	localparam cell_op_t CELL_DEL  = 2'd2;
	localparam cell_op_t CELL_ROT  = 2'd3;

	typedef struct packed {
		cell_op_t op;
		logic     occ;     // cell holds a live entry
		logic     at_end;  // first free slot
		logic     at_tail; // last live entry
	} cell_ctrl_t;

endpackage

>>> hw/rtl/ssid_req_if.sv
// ----------------------------------------------------------------------------
// ssid_req_if
// Request channel: valid/ready with request code and value.
// ----------------------------------------------------------------------------
interface ssid_req_if;
	import ssid_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [REQ_W-1:0]           req_type;
	logic signed [VALUE_W-1:0]  value;

	modport source (output valid, output req_type, output value, input ready);
	modport sink (input valid, input req_type, input value, output ready);
endinterface

>>> hw/rtl/ssid_rsp_if.sv
// ----------------------------------------------------------------------------
// ssid_rsp_if
// Result channel: valid/ready with status and dumped entry.
// ----------------------------------------------------------------------------
interface ssid_rsp_if;
	import ssid_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [STATUS_W-1:0]        status;
	logic signed [VALUE_W-1:0]  entry_value;
	logic                       entry_valid;
	logic                       last;

	modport source (output valid, output status, output entry_value,
		output entry_valid, output last, input ready);
	modport sink (input valid, input status, input entry_value,
		input entry_valid, input last, output ready);
endinterface

>>> hw/rtl/ssid_cell.sv
// ----------------------------------------------------------------------------
// ssid_cell
// One slot of the sorted chain: compares against the request value and
// takes its left, right or head neighbor, the new value, or holds.
// ----------------------------------------------------------------------------
module ssid_cell (
	input  logic                               clk,
	input  ssid_pkg::cell_ctrl_t               ctrl,
	input  logic signed [ssid_pkg::VALUE_W-1:0] req_value,
	input  logic                               prev_shift,
	input  logic signed [ssid_pkg::VALUE_W-1:0] left_value,
	input  logic signed [ssid_pkg::VALUE_W-1:0] right_value,
	input  logic signed [ssid_pkg::VALUE_W-1:0] head_value,
	output logic signed [ssid_pkg::VALUE_W-1:0] value,
	output logic                               shift,
	output logic                               match
);
	import ssid_pkg::*;

	logic signed [VALUE_W-1:0] value_q;

	// live and >= request value: this slot is at or past the sort position
	assign shift = ctrl.occ && (value_q >= req_value);
	assign match = ctrl.occ && (value_q == req_value);
	assign value = value_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_INS: begin
				if (prev_shift) begin
					value_q <= left_value;
				end else if (shift || ctrl.at_end) begin
					value_q <= req_value;
				end
			end
			CELL_DEL: begin
				if (shift) begin
					value_q <= right_value;
				end
			end
			CELL_ROT: begin
				if (ctrl.at_tail) begin
					value_q <= head_value;
				end else if (ctrl.occ) begin
					value_q <= right_value;
				end
			end
			default: begin
			end
		endcase
	end
endmodule

>>> hw/rtl/sorted_store_insert_delete_core.sv
// ----------------------------------------------------------------------------
// Results: an insert or delete result is registered at the accepting edge and
// is valid on the next cycle; a dump first sets its busy state, then its first
// entry is registered. Throughput: inserts and deletes, one per cycle while
// results are taken. Dump of N entries: N results; no request taken until the
// last one has been registered.
// Reset clears the entry count and output valid; slot contents are not reset.
// ----------------------------------------------------------------------------
// sorted_store_insert_delete_core
// Bounded ascending store built as a chain of compare/shift cells.
// ----------------------------------------------------------------------------
module sorted_store_insert_delete_core #(
	parameter int STORE_DEPTH = ssid_pkg::STORE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ssid_req_if.sink   req,
	ssid_rsp_if.source rsp
);
	import ssid_pkg::*;

	localparam int COUNT_W = $clog2(STORE_DEPTH + 1);
	localparam int IDX_W   = $clog2(STORE_DEPTH);

	// chain taps
	logic signed [VALUE_W-1:0] value_w [STORE_DEPTH];
	logic [STORE_DEPTH-1:0]    shift_w;
	logic [STORE_DEPTH-1:0]    match_w;
	cell_ctrl_t                ctrl_w [STORE_DEPTH];

	// control state
	logic [COUNT_W-1:0] count_q;
	logic               dump_busy_q;
	logic [IDX_W-1:0]   dump_idx_q;

	// output register
	logic                      rsp_valid_q;
	logic [STATUS_W-1:0]       status_q;
	logic signed [VALUE_W-1:0] entry_value_q;
	logic                      entry_valid_q;
	logic                      last_q;

	logic     out_free;
	logic     accept;
	logic     full;
	logic     empty;
	logic     found;
	logic     dump_last;
	cell_op_t op;

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = !dump_busy_q && out_free;
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == COUNT_W'(STORE_DEPTH));
	assign empty     = (count_q == '0);
	assign found     = |match_w;
	assign dump_last = (COUNT_W'(dump_idx_q) == COUNT_W'(count_q - COUNT_W'(1)));

	// chain operation for this cycle
	always_comb begin
		op = CELL_HOLD;
		if (accept) begin
			case (req.req_type)
				REQ_INSERT: op = full ? CELL_HOLD : CELL_INS;
				REQ_DELETE: op = (!empty && found) ? CELL_DEL : CELL_HOLD;
				default:    op = CELL_HOLD;
			endcase
		end else if (dump_busy_q && out_free) begin
			// rotate live entries toward cell 0, head wraps to the tail
			op = CELL_ROT;
		end
	end

	// cell row
	for (genvar g = 0; g < STORE_DEPTH; g++) begin : g_cell
		assign ctrl_w[g].op      = op;
		assign ctrl_w[g].occ     = (COUNT_W'(g) < count_q);
		assign ctrl_w[g].at_end  = (COUNT_W'(g) == count_q);
		assign ctrl_w[g].at_tail = (COUNT_W'(g + 1) == count_q);

		ssid_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl_w[g]),
			.req_value   (req.value),
			.prev_shift  ((g == 0) ? 1'b0 : shift_w[(g == 0) ? 0 : g - 1]),
			.left_value  (value_w[(g == 0) ? 0 : g - 1]),
			.right_value (value_w[(g == STORE_DEPTH - 1) ? g : g + 1]),
			.head_value  (value_w[0]),
			.value       (value_w[g]),
			.shift       (shift_w[g]),
			.match       (match_w[g])
		);
	end

	// control and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			dump_busy_q <= 1'b0;
			dump_idx_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				rsp_valid_q <= 1'b0;
			end
			if (op == CELL_INS) begin
				count_q <= count_q + COUNT_W'(1);
			end else if (op == CELL_DEL) begin
				count_q <= count_q - COUNT_W'(1);
			end
			if (accept) begin
				case (req.req_type)
					REQ_INSERT, REQ_DELETE: begin
						rsp_valid_q <= 1'b1;
					end
					REQ_DUMP: begin
						if (empty) begin
							rsp_valid_q <= 1'b1;
						end else begin
							dump_busy_q <= 1'b1;
							dump_idx_q  <= '0;
						end
					end
					default: begin
						// unused code: dropped silently
					end
				endcase
			end else if (dump_busy_q && out_free) begin
				rsp_valid_q <= 1'b1;
				dump_idx_q  <= dump_idx_q + IDX_W'(1);
				if (dump_last) begin
					dump_busy_q <= 1'b0;
				end
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			entry_value_q <= '0;
			entry_valid_q <= 1'b0;
			last_q        <= 1'b1;
			case (req.req_type)
				REQ_INSERT: status_q <= full ? STATUS_FULL : STATUS_OK;
				REQ_DELETE: begin
					if (empty) begin
						status_q <= STATUS_EMPTY;
					end else if (!found) begin
						status_q <= STATUS_NOTFOUND;
					end else begin
						status_q <= STATUS_OK;
					end
				end
				default: status_q <= STATUS_EMPTY;
			endcase
		end else if (dump_busy_q && out_free) begin
			status_q      <= STATUS_OK;
			entry_value_q <= value_w[0];
			entry_valid_q <= 1'b1;
			last_q        <= dump_last;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.entry_value = entry_value_q;
	assign rsp.entry_valid = entry_valid_q;
	assign rsp.last        = last_q;
endmodule

>>> hw/rtl/ssid_checker.sv
// ----------------------------------------------------------------------------
// ssid_checker
// Port-level checks of the sorted store, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_store_insert_delete_core_defines.svh"

module ssid_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                req_ready,
	input logic                                rsp_valid,
	input logic                                rsp_ready,
	input logic [ssid_pkg::STATUS_W-1:0]       rsp_status,
	input logic signed [ssid_pkg::VALUE_W-1:0] rsp_entry_value,
	input logic                                rsp_entry_valid,
	input logic                                rsp_last
);
	import ssid_pkg::*;

	logic                        rsp_stall;
	logic                        rsp_entry;
	logic                        rsp_bare;
	logic [STATUS_W+VALUE_W+1:0] rsp_word;

	assign rsp_stall = rsp_valid && !rsp_ready;
	assign rsp_entry = rsp_valid && rsp_entry_valid;
	assign rsp_bare  = rsp_valid && !rsp_entry_valid;
	assign rsp_word  = {rsp_status, rsp_entry_value, rsp_entry_valid, rsp_last};

	// stalled result holds
	`SSID_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_stall, rsp_valid && $stable(rsp_word))

	// dumped entries always carry ok
	`SSID_ASSERT_NOW(a_entry_ok, clk, arst_n, rsp_entry, rsp_status == STATUS_OK)

	// status-only results are single and zero-valued
	`SSID_ASSERT_NOW(a_status_single, clk, arst_n, rsp_bare, rsp_last && (rsp_entry_value == '0))

	// no request is taken in the middle of a dump
	`SSID_ASSERT_NOW(a_dump_blocks, clk, arst_n, rsp_entry && !rsp_last, !req_ready)
endmodule

bind sorted_store_insert_delete_core ssid_checker u_ssid_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_entry_value (rsp.entry_value),
	.rsp_entry_valid (rsp.entry_valid),
	.rsp_last        (rsp.last)
);

>>> tb/sorted_store_insert_delete_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_store_insert_delete_core_test
// Self-checking bench for the sorted store. A generator queues requests, a
// clocked driver feeds them over the request channel, and a shadow copy of
// the store predicts every result. A clocked monitor compares each result,
// field by field, with the oldest prediction. Both channels idle at random.
// ----------------------------------------------------------------------------
module sorted_store_insert_delete_core_test;
	import ssid_pkg::*;

	localparam int DEPTH = STORE_DEPTH_DEF;
	// Request code with no meaning; the block must drop it silently.
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 190;
	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 24;

	typedef struct packed {
		logic [REQ_W-1:0]          kind;
		logic signed [VALUE_W-1:0] value;
	} store_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]       status;
		logic signed [VALUE_W-1:0] entry_value;
		logic                      entry_valid;
		logic                      last;
	} store_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ssid_req_if req_ch ();
	ssid_rsp_if rsp_ch ();

	sorted_store_insert_delete_core #(
		.STORE_DEPTH(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Generator output, shadow store contents, and results still owed.
	store_req_t                 req_backlog[$];
	logic signed [VALUE_W-1:0]  shadow_store[$];
	store_rsp_t                 due_rsp[$];
	logic signed [VALUE_W-1:0]  insert_pool[$];

	int unsigned cyc;
	int unsigned quiet_cycles;
	int unsigned fail_cnt;

	// --------------------------------------------------------------------
	// Shadow store. Called once per accepted item; queues the results that
	// the item must produce, in order.
	// --------------------------------------------------------------------
	task automatic store_apply(input store_req_t item);
		int pos;
		store_rsp_t r;
		begin
			r = '0;
			r.last = 1'b1;
			case (item.kind)
				REQ_INSERT: begin
					if (shadow_store.size() >= DEPTH) begin
						// full store: refused, contents untouched
						r.status = STATUS_FULL;
					end else begin
						// new value lands ahead of any equal entries
						pos = 0;
						while (pos < shadow_store.size() && shadow_store[pos] < item.value)
							pos++;
						shadow_store.insert(pos, item.value);
						r.status = STATUS_OK;
					end
					due_rsp.push_back(r);
				end
				REQ_DELETE: begin
					if (shadow_store.size() == 0) begin
						r.status = STATUS_EMPTY;
					end else begin
						pos = 0;
						while (pos < shadow_store.size() && shadow_store[pos] != item.value)
							pos++;
						if (pos >= shadow_store.size()) begin
							r.status = STATUS_NOTFOUND;
						end else begin
							shadow_store.delete(pos);
							r.status = STATUS_OK;
						end
					end
					due_rsp.push_back(r);
				end
				REQ_DUMP: begin
					if (shadow_store.size() == 0) begin
						// empty dump still answers once
						r.status = STATUS_EMPTY;
						due_rsp.push_back(r);
					end else begin
						foreach (shadow_store[i]) begin
							r.status      = STATUS_OK;
							r.entry_value = shadow_store[i];
							r.entry_valid = 1'b1;
							r.last        = (i == shadow_store.size() - 1);
							due_rsp.push_back(r);
						end
					end
				end
				default: begin
					// unused code: no result, no state change
				end
			endcase
		end
	endtask

	// Both sides stall about 24% of cycles, except in every fourth window of
	// the cycle counter, which runs flat out.
	function automatic bit take_break();
		if (((cyc / 300) % 4) == 3)
			return 1'b0;
		return $urandom_range(0, 99) < 24;
	endfunction

	// Biased toward small values so that duplicates and equal-entry
	// ordering show up often.
	function automatic logic signed [VALUE_W-1:0] pick_value();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 5)
			return $signed(VALUE_W'($urandom_range(0, 16))) - 8;
		if (sel == 5) begin
			case ($urandom_range(0, 3))
				0: return 32'sh7fffffff;
				1: return 32'sh80000000;
				2: return '0;
				default: return -1;
			endcase
		end
		return $signed($urandom);
	endfunction

	task automatic queue_req(input logic [REQ_W-1:0] kind,
			input logic signed [VALUE_W-1:0] value);
		store_req_t item;
		begin
			item.kind  = kind;
			item.value = value;
			req_backlog.push_back(item);
			if (kind == REQ_INSERT) begin
				insert_pool.push_back(value);
				if (insert_pool.size() > 32)
					void'(insert_pool.pop_front());
			end
		end
	endtask

	// --------------------------------------------------------------------
	// Driver: holds the item while it is stalled, predicts on accept, then
	// presents the next item or idles. One NBA per signal per edge.
	// --------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		store_req_t nxt;
		if (!arst_n) begin
			req_ch.valid    <= 1'b0;
			req_ch.req_type <= REQ_INSERT;
			req_ch.value    <= '0;
		end else if (!(req_ch.valid && !req_ch.ready)) begin
			if (req_ch.valid) begin
				nxt.kind  = req_ch.req_type;
				nxt.value = req_ch.value;
				store_apply(nxt);
			end
			if (req_backlog.size() > 0 && !take_break()) begin
				nxt = req_backlog.pop_front();
				req_ch.valid    <= 1'b1;
				req_ch.req_type <= nxt.kind;
				req_ch.value    <= nxt.value;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// --------------------------------------------------------------------
	// Monitor: checks each accepted result against the oldest prediction,
	// then picks the ready for the next cycle.
	// --------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		store_rsp_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (due_rsp.size() == 0) begin
					$display("%0t: unexpected result, expected none, got status %0d value %0d",
						$time, rsp_ch.status, rsp_ch.entry_value);
					fail_cnt++;
				end else begin
					want = due_rsp.pop_front();
					if (rsp_ch.status !== want.status) begin
						$display("%0t: status mismatch, expected %0d, got %0d",
							$time, want.status, rsp_ch.status);
						fail_cnt++;
					end
					if (rsp_ch.entry_value !== want.entry_value) begin
						$display("%0t: entry_value mismatch, expected %0d, got %0d",
							$time, want.entry_value, rsp_ch.entry_value);
						fail_cnt++;
					end
					if (rsp_ch.entry_valid !== want.entry_valid) begin
						$display("%0t: entry_valid mismatch, expected %0d, got %0d",
							$time, want.entry_valid, rsp_ch.entry_valid);
						fail_cnt++;
					end
					if (rsp_ch.last !== want.last) begin
						$display("%0t: last mismatch, expected %0d, got %0d",
							$time, want.last, rsp_ch.last);
						fail_cnt++;
					end
				end
			end
			rsp_ch.ready <= !take_break();
		end
	end

	// Watchdog: ends the run after too long with no handshake on either side.
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// --------------------------------------------------------------------
	// Stimulus and end of run.
	// --------------------------------------------------------------------
	initial begin
		int counted;
		int phase_grow;
		int roll;
		logic signed [VALUE_W-1:0] v;

		cyc          = 0;
		quiet_cycles = 0;
		fail_cnt     = 0;
		req_ch.valid    = 1'b0;
		req_ch.req_type = REQ_INSERT;
		req_ch.value    = '0;
		rsp_ch.ready    = 1'b0;

		// Directed: empty-store answers, extremes, duplicates, a miss,
		// the unused code, filling to the brim and a refused insert.
		queue_req(REQ_DUMP, 32'sd0);
		queue_req(REQ_DELETE, 32'sd7);
		queue_req(REQ_INSERT, 32'sh7fffffff);
		queue_req(REQ_INSERT, 32'sh80000000);
		queue_req(REQ_INSERT, 32'sd0);
		queue_req(REQ_INSERT, 32'sd0);
		queue_req(REQ_INSERT, -32'sd1);
		queue_req(REQ_DELETE, 32'sd5);
		queue_req(REQ_DELETE, 32'sd0);
		queue_req(REQ_UNUSED, -32'sd1);
		for (int i = 0; i < 12; i++)
			queue_req(REQ_INSERT, 32'(i * 3 - 17));
		queue_req(REQ_INSERT, 32'sd42);
		queue_req(REQ_DUMP, 32'sd0);
		queue_req(REQ_DELETE, 32'sh7fffffff);

		// Random: alternating grow and shrink phases so the store sweeps
		// between empty and full; deletes mostly aim at values that were
		// inserted recently.
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			phase_grow = ((counted / 30) % 2) == 0;
			roll = $urandom_range(0, 99);
			if (roll < 3) begin
				queue_req(REQ_UNUSED, $signed($urandom));
			end else begin
				counted++;
				if (roll < 15) begin
					queue_req(REQ_DUMP, $signed($urandom));
				end else if ((roll < 65) == phase_grow) begin
					queue_req(REQ_INSERT, pick_value());
				end else begin
					if (insert_pool.size() > 0 && $urandom_range(0, 9) < 6)
						v = insert_pool[$urandom_range(0, insert_pool.size() - 1)];
					else
						v = pick_value();
					queue_req(REQ_DELETE, v);
				end
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// all items handed over, then all results in, then a short drain
		while (req_backlog.size() > 0 || req_ch.valid)
			@(posedge clk);
		while (due_rsp.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
